/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define AST_IMP(lbl, ck, rn, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ant) |-> (con)) \
    else $error("same-cycle implication violated");

// next-cycle implication, off while reset is held
`define AST_NXT(lbl, ck, rn, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ant) |=> (con)) \
    else $error("next-cycle implication violated");

`endif

/* hdl/qrl_pkg.sv */
package qrl_pkg;

  // operation select carried in the func field
  localparam logic FUNC_DIV = 1'b0;
  localparam logic FUNC_LOG = 1'b1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* hdl/qrl_in_if.sv */
interface qrl_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [DATA_WIDTH-1:0] value_a;
  logic [DATA_WIDTH-1:0] value_b;

  modport source (output valid, output func, output value_a, output value_b, input ready);
  modport sink (input valid, input func, input value_a, input value_b, output ready);
endinterface

/* hdl/qrl_out_if.sv */
interface qrl_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder;
  logic                  bad_operand;

  modport source (output valid, output quotient, output remainder, output bad_operand,
                  input ready);
  modport sink (input valid, input quotient, input remainder, input bad_operand,
                output ready);
endinterface

/* hdl/quotient_remainder_or_log_top.sv */
// channel  | modport | beat contents
// in_bus   | sink    | func, value_a, value_b
// out_bus  | source  | quotient, remainder, bad_operand
//
// division: one shared restoring divider, one quotient bit per cycle
// logarithm: the divider reruns once per power k found
// bad operands and a log of a value below its base skip the divider and go to S_OUT
// in_bus.ready is high only when idle; a finished result waits while out_bus stalls
// rst_n is synchronous and clears the sequencer and the output valid

`include "assert_macros.svh"

module quotient_remainder_or_log_top #(
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  qrl_in_if.sink   in_bus,
  qrl_out_if.source out_bus
);
  import qrl_pkg::*;

  localparam int K_W = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  state_t                state_r;
  logic                  func_r;
  logic [DATA_WIDTH-1:0] b_r;
  logic [K_W-1:0]        k_r;
  logic [DATA_WIDTH-1:0] res_q_r;
  logic [DATA_WIDTH-1:0] res_r_r;
  logic                  res_bad_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_q_r;
  logic [DATA_WIDTH-1:0] out_rem_r;
  logic                  out_bad_r;

  logic                  in_acc;
  logic                  bad_in;
  logic                  a_lt_b;
  logic                  log_more;
  logic [K_W-1:0]        k_inc;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_a;
  logic [DATA_WIDTH-1:0] div_q;
  logic [DATA_WIDTH-1:0] div_rem;
  div_sts_t              div_sts;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_comb begin
    a_lt_b = in_bus.value_a < in_bus.value_b;
    if (in_bus.func == FUNC_DIV) begin
      bad_in = (in_bus.value_b == '0);
    end else begin
      bad_in = (in_bus.value_b[DATA_WIDTH-1:1] == '0) || (in_bus.value_a == '0);
    end
  end

  // log: keep dividing by the base while the running value is still >= base
  assign log_more = div_q >= b_r;
  assign k_inc    = k_r + 1'b1;

  assign div_start = (in_acc && !bad_in && !(in_bus.func == FUNC_LOG && a_lt_b)) ||
                     (state_r == S_DIV && div_sts.done && func_r == FUNC_LOG && log_more);
  assign div_a     = (state_r == S_IDLE) ? in_bus.value_a : div_q;

  qrl_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   ((state_r == S_IDLE) ? in_bus.value_b : b_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_bus.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r <= in_bus.func;
            b_r    <= in_bus.value_b;
            k_r    <= '0;
            if (bad_in) begin
              res_q_r   <= '0;
              res_r_r   <= '0;
              res_bad_r <= 1'b1;
              state_r   <= S_OUT;
            end else if (in_bus.func == FUNC_LOG && a_lt_b) begin
              res_q_r   <= '0;
              res_r_r   <= in_bus.value_a;
              res_bad_r <= 1'b0;
              state_r   <= S_OUT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_bad_r <= 1'b0;
            if (func_r == FUNC_DIV) begin
              res_q_r <= div_q;
              res_r_r <= div_rem;
              state_r <= S_OUT;
            end else begin
              k_r <= k_inc;
              if (!log_more) begin
                res_q_r <= DATA_WIDTH'(k_inc);
                res_r_r <= div_q;
                state_r <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_q_r   <= res_q_r;
            out_rem_r <= res_r_r;
            out_bad_r <= res_bad_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.quotient    = out_q_r;
  assign out_bus.remainder   = out_rem_r;
  assign out_bus.bad_operand = out_bad_r;

  `AST_IMP(a_ready_div_idle, clk, rst_n, in_bus.ready, !div_sts.busy)
  `AST_IMP(a_done_in_div, clk, rst_n, div_sts.done, state_r == S_DIV)
  `AST_IMP(a_bad_zero, clk, rst_n, out_valid_r && out_bad_r, out_q_r == '0 && out_rem_r == '0)

endmodule

/* hdl/qrl_div.sv */
`include "assert_macros.svh"

module qrl_div #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder,
  output qrl_pkg::div_sts_t     sts
);
  import qrl_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] divisor_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  borrow;

  // restoring step: bring in the next dividend bit, try to subtract
  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_r};
  assign borrow  = diff[DATA_WIDTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        divisor_r <= divisor;
        rem_r     <= '0;
        quo_r     <= dividend;
        cnt_r     <= CNT_INIT;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        rem_r <= borrow ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], ~borrow};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;

  `AST_IMP(a_start_idle, clk, rst_n, start, !busy_r)
  `AST_NXT(a_start_busy, clk, rst_n, start, busy_r && !done_r)
  `AST_IMP(a_rem_below, clk, rst_n, done_r, rem_r < divisor_r)

endmodule

/* dv/tb_quotient_remainder_or_log_top.sv */
`timescale 1ns / 1ps

module tb_quotient_remainder_or_log_top;
  import qrl_pkg::*;

  localparam int DW = 32;
  localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 10_000_000;

  typedef struct {
    logic          func;
    logic [DW-1:0] value_a;
    logic [DW-1:0] value_b;
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic          bad_operand;
  } qrl_result_t;

  logic clk;
  logic rst_n;

  qrl_in_if #(.DATA_WIDTH(DW)) in_bus ();
  qrl_out_if #(.DATA_WIDTH(DW)) out_bus ();

  quotient_remainder_or_log_top #(.DATA_WIDTH(DW)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  qrl_result_t awaited_qr[$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;
  bit          src_idle_on = 1'b1;
  logic        sink_idle_on;
  logic        sink_holding;
  event        start_hold;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_qr.size());
      $display("status: fail");
      $finish;
    end
  end

  // quotient/remainder or integer log, with exact compares on 64 bits
  function automatic qrl_result_t predict_qrl(logic f, logic [DW-1:0] a, logic [DW-1:0] b);
    qrl_result_t    res;
    longint unsigned pw;
    longint unsigned lim;
    int unsigned     k;
    res.func = f;
    res.value_a = a;
    res.value_b = b;
    res.quotient = '0;
    res.remainder = '0;
    res.bad_operand = 1'b0;
    if (f == FUNC_DIV) begin
      if (b == '0) begin
        res.bad_operand = 1'b1;
      end else begin
        res.quotient = a / b;
        res.remainder = a % b;
      end
    end else if (b < 2 || a == '0) begin
      res.bad_operand = 1'b1;
    end else begin
      pw = 1;
      k = 0;
      lim = longint'(a) / longint'(b);
      while (pw <= lim) begin
        pw = pw * b;
        k++;
      end
      res.quotient = DW'(k);
      res.remainder = DW'(longint'(a) / pw);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // valid stays high after a beat so back-to-back beats need no toggle
  task automatic send_operands(input logic f, input logic [DW-1:0] a, input logic [DW-1:0] b);
    if (src_idle_on) begin
      while ($urandom_range(99) < 29) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid   <= 1'b1;
    in_bus.func    <= f;
    in_bus.value_a <= a;
    in_bus.value_b <= b;
    do @(posedge clk); while (!in_bus.ready);
    awaited_qr.push_back(predict_qrl(f, a, b));
  endtask

  task automatic wait_results_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaited_qr.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (sink_holding) begin
      out_bus.ready <= 1'b0;
    end else if (sink_idle_on) begin
      out_bus.ready <= ($urandom_range(99) >= 29);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  initial begin
    sink_holding <= 1'b0;
    forever begin
      @(start_hold);
      sink_holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin : check_beat
      qrl_result_t want;
      if (awaited_qr.size() == 0) begin
        report_mismatch("result beat with nothing awaited");
      end else begin
        want = awaited_qr.pop_front();
        if (out_bus.quotient !== want.quotient)
          report_mismatch($sformatf("func=%0d a=%h b=%h quotient %h, want %h", want.func,
                                    want.value_a, want.value_b, out_bus.quotient,
                                    want.quotient));
        if (out_bus.remainder !== want.remainder)
          report_mismatch($sformatf("func=%0d a=%h b=%h remainder %h, want %h", want.func,
                                    want.value_a, want.value_b, out_bus.remainder,
                                    want.remainder));
        if (out_bus.bad_operand !== want.bad_operand)
          report_mismatch($sformatf("func=%0d a=%h b=%h bad_operand %b, want %b", want.func,
                                    want.value_a, want.value_b, out_bus.bad_operand,
                                    want.bad_operand));
      end
    end
  end

  task automatic test_division_edges();
    send_operands(FUNC_DIV, '0, 32'd1);
    send_operands(FUNC_DIV, ALL_ONES, 32'd1);
    send_operands(FUNC_DIV, ALL_ONES, ALL_ONES);
    send_operands(FUNC_DIV, '0, ALL_ONES);
    send_operands(FUNC_DIV, ALL_ONES - 1, ALL_ONES);
    send_operands(FUNC_DIV, 32'h8000_0000, 32'd3);
    send_operands(FUNC_DIV, 32'd12345, 32'd7);
    send_operands(FUNC_DIV, ALL_ONES, 32'h8000_0000);
    // division by zero
    send_operands(FUNC_DIV, ALL_ONES, '0);
    send_operands(FUNC_DIV, '0, '0);
    wait_results_drained();
  endtask

  task automatic test_log_edges();
    // base below two and log of zero
    send_operands(FUNC_LOG, 32'd100, '0);
    send_operands(FUNC_LOG, ALL_ONES, 32'd1);
    send_operands(FUNC_LOG, '0, 32'd10);
    send_operands(FUNC_LOG, '0, '0);
    // value below base
    send_operands(FUNC_LOG, 32'd5, 32'd10);
    send_operands(FUNC_LOG, ALL_ONES - 1, ALL_ONES);
    send_operands(FUNC_LOG, 32'd1, 32'd2);
    // exact powers
    send_operands(FUNC_LOG, 32'd1000, 32'd10);
    send_operands(FUNC_LOG, 32'h8000_0000, 32'd2);
    send_operands(FUNC_LOG, ALL_ONES, ALL_ONES);
    // deepest loop and general residues
    send_operands(FUNC_LOG, ALL_ONES, 32'd2);
    send_operands(FUNC_LOG, ALL_ONES, 32'h0001_0000);
    send_operands(FUNC_LOG, 32'h8000_0000, 32'h0001_0000);
    wait_results_drained();
  endtask

  task automatic test_random_mix(input int n_items);
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    longint unsigned pw;
    int unsigned     k;
    int unsigned     pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        send_operands(FUNC_DIV, $urandom(), $urandom());
      end else if (pick < 34) begin
        a = $urandom() >> $urandom_range(0, 31);
        b = $urandom() >> $urandom_range(0, 31);
        send_operands(FUNC_DIV, a, b);
      end else if (pick < 42) begin
        b = $urandom() | 32'd1;
        send_operands(FUNC_DIV, $urandom_range(0, b - 1), b);
      end else if (pick < 45) begin
        send_operands(FUNC_DIV, $urandom(), '0);
      end else if (pick < 50) begin
        // small bases run the divider loop many times
        send_operands(FUNC_LOG, $urandom(), $urandom_range(2, 16));
      end else if (pick < 72) begin
        b = $urandom() >> $urandom_range(0, 28);
        if (b < 2) b = b + 2;
        send_operands(FUNC_LOG, $urandom() >> $urandom_range(0, 8), b);
      end else if (pick < 80) begin
        b = $urandom() | 32'd2;
        send_operands(FUNC_LOG, $urandom_range(1, b - 1), b);
      end else if (pick < 90) begin
        b = $urandom_range(2, 300);
        k = $urandom_range(1, 31);
        pw = 1;
        repeat (k) begin
          if (pw * b <= longint'(ALL_ONES)) pw = pw * b;
        end
        send_operands(FUNC_LOG, pw[DW-1:0], b);
      end else if (pick < 95) begin
        send_operands(FUNC_LOG, $urandom(), $urandom_range(0, 1));
      end else begin
        send_operands(FUNC_LOG, '0, $urandom());
      end
    end
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    -> start_hold;
    repeat (12) begin
      send_operands(FUNC_DIV, $urandom(), $urandom() >> $urandom_range(0, 31));
    end
    wait_results_drained();
  endtask

  task automatic test_steady_stream(input int n_items);
    src_idle_on = 1'b0;
    sink_idle_on <= 1'b0;
    repeat (n_items) begin
      if ($urandom_range(1)) begin
        send_operands(FUNC_DIV, $urandom(), $urandom() >> $urandom_range(0, 31));
      end else begin
        send_operands(FUNC_LOG, $urandom(), $urandom() | 32'h100);
      end
    end
    wait_results_drained();
    src_idle_on = 1'b1;
    sink_idle_on <= 1'b1;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.func    <= FUNC_DIV;
    in_bus.value_a <= '0;
    in_bus.value_b <= '0;
    sink_idle_on   <= 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_division_edges();
    test_log_edges();
    test_random_mix(1500);
    test_backpressure();
    test_steady_stream(350);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/qrl_pkg.sv
hdl/qrl_in_if.sv
hdl/qrl_out_if.sv
hdl/qrl_div.sv
hdl/quotient_remainder_or_log_top.sv
dv/tb_quotient_remainder_or_log_top.sv
